// ===== design/cc20_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_pkg
// Types and constants shared by the ChaCha20 stream cipher modules.
// ----------------------------------------------------------------------------
package cc20_pkg;

  typedef logic [31:0]       cc20_word_t;
  typedef logic [15:0][31:0] cc20_block_t;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][31:0] CC20_SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR = 3'd6;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINAL
  } cc20_core_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_EMIT
  } cc20_st_t;

endpackage
`default_nettype wire

// ===== design/cc20_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_in_if
// Input byte channel: valid/ready handshake with data byte and last flag.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== design/cc20_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_out_if
// Result byte channel: valid/ready handshake with result byte and last flag.
// ----------------------------------------------------------------------------
interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// ===== design/cc20_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_core
// Keystream block generator: one shared half quarter-round unit per cycle,
// state kept as a 4x4 word matrix whose rows rotate so the unit always
// works on fixed taps.
// ----------------------------------------------------------------------------
module cc20_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cc20_pkg::cc20_block_t init_words,
  output logic                done,
  output cc20_pkg::cc20_block_t ks_words
);
  import cc20_pkg::*;

  localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  cc20_core_st_t   st_r, st_nxt;
  cc20_block_t     mix_r, mix_nxt;
  logic [3:0]      step_r, step_nxt;
  logic [DR_W-1:0] dr_r, dr_nxt;

  logic load_en, round_en, final_en;
  logic half, diag, last_step, last_round;
  logic [3:0] idx_b, idx_c, idx_d;
  cc20_word_t qa, qb, qc, qd, a1, d0, d1, c1, b0, b1;
  cc20_block_t wb, rot, sum;

  assign half       = step_r[0];
  assign diag       = step_r[3];
  assign last_step  = (step_r == 4'hF);
  assign last_round = (dr_r == DR_W'(DOUBLE_ROUNDS - 1));

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CORE_IDLE:  if (start) st_nxt = CORE_ROUND;
      CORE_ROUND: if (last_step && last_round) st_nxt = CORE_FINAL;
      CORE_FINAL: st_nxt = CORE_IDLE;
      default:    st_nxt = CORE_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    load_en  = 1'b0;
    round_en = 1'b0;
    final_en = 1'b0;
    unique case (st_r)
      CORE_IDLE:  load_en  = start;
      CORE_ROUND: round_en = 1'b1;
      CORE_FINAL: final_en = 1'b1;
      default: ;
    endcase
  end

  assign done     = final_en;
  assign ks_words = mix_r;

  // column taps in the first half of a double round, diagonal taps after
  always_comb begin
    idx_b = diag ? 4'd5  : 4'd4;
    idx_c = diag ? 4'd10 : 4'd8;
    idx_d = diag ? 4'd15 : 4'd12;
    qa = mix_r[0];
    qb = mix_r[idx_b];
    qc = mix_r[idx_c];
    qd = mix_r[idx_d];
    a1 = qa + qb;
    d0 = qd ^ a1;
    d1 = half ? {d0[23:0], d0[31:24]} : {d0[15:0], d0[31:16]};
    c1 = qc + d1;
    b0 = qb ^ c1;
    b1 = half ? {b0[24:0], b0[31:25]} : {b0[19:0], b0[31:20]};
  end

  always_comb begin
    wb = mix_r;
    wb[0]     = a1;
    wb[idx_b] = b1;
    wb[idx_c] = c1;
    wb[idx_d] = d1;
    // each row moves one word toward column 0 after a full quarter round
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        rot[4*r+c] = wb[4*r+((c+1)%4)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sum[i] = mix_r[i] + init_words[i];
    end
  end

  always_comb begin
    mix_nxt  = mix_r;
    step_nxt = step_r;
    dr_nxt   = dr_r;
    if (load_en) begin
      mix_nxt  = init_words;
      step_nxt = '0;
      dr_nxt   = '0;
    end else if (round_en) begin
      mix_nxt  = half ? rot : wb;
      step_nxt = step_r + 4'd1;
      if (last_step) begin
        dr_nxt = dr_r + DR_W'(1);
      end
    end else if (final_en) begin
      mix_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CORE_IDLE;
      step_r <= '0;
      dr_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      dr_r   <= dr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= mix_nxt;
  end

endmodule
`default_nettype wire

// ===== design/chacha20_stream_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte stream cipher: each input byte is XORed with keystream.
// ----------------------------------------------------------------------------
// Usage:
//   Load key, nonce and initial block counter through the cfg_ write port
//   while the block is idle. Bytes enter on in_chan, one per transfer, with
//   last_byte marking the end of a message; each gives one byte on out_chan
//   with out_last copied through. The next byte after a last byte restarts
//   the stream at the initial counter.
// Sequence:
//   A byte that falls inside the current keystream block is accepted, then
//   loaded into the output register. A byte at block position zero first
//   builds a 64-byte block: a load of the core state, 16 half quarter rounds
//   per double round (one half quarter round per cycle through the shared
//   round unit), the final add, then the output load.
// Reset clears the configuration, the byte position and the output valid;
// the first byte then starts a message. While out_chan stalls, one result
// waits in the output register and one more byte can be accepted and
// processed up to its output load.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data,
  cc20_in_if.sink                           in_chan,
  cc20_out_if.source                        out_chan
);
  import cc20_pkg::*;

  cc20_st_t    st_r, st_nxt;
  logic [3:0][63:0] key_r;
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] init_ctr_r;

  logic [31:0] block_count_r, block_count_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        msg_start_r, msg_start_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_ready, in_xfer, emit, core_start, core_done;
  logic [5:0]  pos_eff;
  logic [31:0] ctr_sel;
  cc20_block_t init_words, ks_words;
  cc20_word_t  ks_word;
  logic [7:0]  ks_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      init_ctr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0:     key_r[0]   <= cfg_data;
        CFG_KEY1:     key_r[1]   <= cfg_data;
        CFG_KEY2:     key_r[2]   <= cfg_data;
        CFG_KEY3:     key_r[3]   <= cfg_data;
        CFG_NONCE_LO: nonce_lo_r <= cfg_data;
        CFG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
        CFG_INIT_CTR: init_ctr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_xfer = in_chan.valid && in_ready;
  assign pos_eff = msg_start_r ? 6'd0 : pos_r;

  // the counter word comes straight from the config on the first byte
  assign ctr_sel = (st_r == ST_IDLE && msg_start_r) ? init_ctr_r : block_count_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_words[i]       = CC20_SIGMA[i];
      init_words[4 + 2*i] = key_r[i][31:0];
      init_words[5 + 2*i] = key_r[i][63:32];
    end
    init_words[12] = ctr_sel;
    init_words[13] = nonce_lo_r[31:0];
    init_words[14] = nonce_lo_r[63:32];
    init_words[15] = nonce_hi_r;
  end

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (core_start),
    .init_words (init_words),
    .done       (core_done),
    .ks_words   (ks_words)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_xfer) st_nxt = (pos_eff == 6'd0) ? ST_BLOCK : ST_EMIT;
      ST_BLOCK: if (core_done) st_nxt = ST_EMIT;
      ST_EMIT:  if (emit) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    emit       = 1'b0;
    core_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        core_start = in_chan.valid && (pos_eff == 6'd0);
      end
      ST_EMIT:  emit = !out_valid_r || out_chan.ready;
      ST_BLOCK: ;
      default: ;
    endcase
  end

  assign ks_word = ks_words[pos_r[5:2]];
  assign ks_byte = 8'(ks_word >> {pos_r[1:0], 3'b000});

  always_comb begin
    block_count_nxt = block_count_r;
    pos_nxt         = pos_r;
    msg_start_nxt   = msg_start_r;
    byte_nxt        = byte_r;
    last_nxt        = last_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    if (in_xfer) begin
      byte_nxt      = in_chan.data_byte;
      last_nxt      = in_chan.last_byte;
      pos_nxt       = pos_eff;
      msg_start_nxt = 1'b0;
      if (msg_start_r) begin
        block_count_nxt = init_ctr_r;
      end
    end
    if (core_done) begin
      block_count_nxt = block_count_r + 32'd1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_r ^ ks_byte;
      out_last_nxt  = last_r;
      // a last byte drops the rest of the block
      pos_nxt       = last_r ? 6'd0 : pos_r + 6'd1;
      msg_start_nxt = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      block_count_r <= '0;
      pos_r         <= '0;
      msg_start_r   <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      block_count_r <= block_count_nxt;
      pos_r         <= pos_nxt;
      msg_start_r   <= msg_start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.out_last = out_last_r;

endmodule
`default_nettype wire
